FILE: rtl/rpg_pkg.sv
package rpg_pkg;

  // Configuration port geometry
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 64;

  // Fixed stage counts of the pipeline sections
  localparam int unsigned FrontLat = 6;
  localparam int unsigned NormLat  = 7;
  localparam int unsigned SqrtLat  = 33;

  localparam logic signed [31:0] S32Max = 32'sh7fff_ffff;
  localparam logic signed [31:0] S32Min = 32'sh8000_0000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_ROW0,
    REG_ROW1,
    REG_ROW2,
    REG_ROW3,
    REG_TAN,
    REG_TAN_ASP,
    REG_STEP_X,
    REG_STEP_Y
  } cfg_reg_e;

  typedef struct packed {
    logic [11:0] pixel_x;
    logic [11:0] pixel_y;
  } pix_in_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
  } ray_out_t;

  typedef struct packed {
    logic [3:0][63:0] row;
    logic [31:0]      tan_half_fov;
    logic [31:0]      tan_half_fov_aspect;
    logic [31:0]      step_x;
    logic [31:0]      step_y;
  } cam_cfg_t;

  // Clamp to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (v > 64'(S32Max)) begin
      r = S32Max;
    end else if (v < 64'(S32Min)) begin
      r = S32Min;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

  // Signed Q8.8 matrix element, column c of a packed row
  function automatic logic signed [15:0] elem(input logic [63:0] row, input logic [1:0] c);
    return row[16*c +: 16];
  endfunction

endpackage

FILE: rtl/pinhole_camera_ray_generator_unit.sv
// Pinhole camera primary ray generator. Pulse start with a pixel (pixel_x,
// pixel_y); for each such pixel res_valid_o is later high for exactly one
// cycle with the camera origin and the unit ray direction in signed Q16.16.
// busy is never raised: a new pixel may enter every cycle, and results leave
// in entry order with no way to hold them off, so the receiver must take each
// one when it appears. Most of the pipeline lies in the two bit-per-stage
// dividers (perspective divide and normalization) and the bit-per-stage
// square root. Matrix and camera registers are written through the cfg port
// and must only change while no pixel is in flight.
module pinhole_camera_ray_generator_unit import rpg_pkg::*; #(
  parameter int PIXEL_COORD_BITS = 12,
  parameter int FRAC_BITS        = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  pix_in_t             pix_i,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_idx_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output logic                res_valid_o,
  output ray_out_t            res_o
);

  localparam int DivLat   = 32 + FRAC_BITS + 2;
  localparam int SubStage = FrontLat + DivLat + 1;
  localparam int NormOut  = SubStage + NormLat;
  localparam int SqrtOut  = NormOut + SqrtLat;
  localparam int PipeLat  = SqrtOut + DivLat + 1;
  localparam int OrgDly   = NormLat + SqrtLat + DivLat;
  localparam logic signed [31:0] DirOne = 32'sd1 <<< FRAC_BITS;

  cam_cfg_t           cfg_q;
  logic [PipeLat-1:0] vld_q;
  logic               accept;
  logic signed [31:0] p    [4];
  logic signed [31:0] q1   [6];
  logic signed [32:0] d_q  [3];
  logic [95:0]        org_s_q;
  logic [95:0]        org_dl_q [OrgDly];
  logic signed [31:0] dn   [3];
  logic [63:0]        sum;
  logic               zero_n;
  logic [31:0]        root;
  logic [96:0]        sq_dl_q [SqrtLat];
  logic               zd_dl_q [DivLat];
  logic signed [31:0] q2   [3];
  ray_out_t           res_q;
  logic               zero_out_q;

  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.row[0]               <= 64'h0000_0000_0000_0100;
      cfg_q.row[1]               <= 64'h0000_0000_0100_0000;
      cfg_q.row[2]               <= 64'h0000_0100_0000_0000;
      cfg_q.row[3]               <= 64'h0100_0000_0000_0000;
      cfg_q.tan_half_fov         <= 32'(64'd1 << FRAC_BITS);
      cfg_q.tan_half_fov_aspect  <= 32'(64'd1 << FRAC_BITS);
      cfg_q.step_x               <= 32'd128;
      cfg_q.step_y               <= 32'd128;
    end else if (cfg_we_i) begin
      unique case (cfg_reg_e'(cfg_idx_i))
        REG_ROW0:    cfg_q.row[0]              <= cfg_wdata_i;
        REG_ROW1:    cfg_q.row[1]              <= cfg_wdata_i;
        REG_ROW2:    cfg_q.row[2]              <= cfg_wdata_i;
        REG_ROW3:    cfg_q.row[3]              <= cfg_wdata_i;
        REG_TAN:     cfg_q.tan_half_fov        <= cfg_wdata_i[31:0];
        REG_TAN_ASP: cfg_q.tan_half_fov_aspect <= cfg_wdata_i[31:0];
        REG_STEP_X:  cfg_q.step_x              <= cfg_wdata_i[31:0];
        REG_STEP_Y:  cfg_q.step_y              <= cfg_wdata_i[31:0];
      endcase
    end
  end

  // Every cycle takes a transfer; valid bits ride along the pipeline
  assign busy   = 1'b0;
  assign accept = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[PipeLat-2:0], accept};
    end
  end

  // Screen point and matrix product
  rpg_front #(
    .PIXEL_COORD_BITS(PIXEL_COORD_BITS),
    .FRAC_BITS       (FRAC_BITS)
  ) u_front (
    .clk_i (clk_i),
    .pix_i (pix_i),
    .cfg_i (cfg_q),
    .p_o   (p)
  );

  // Perspective divide of the point and of the camera origin
  for (genvar g = 0; g < 6; g++) begin : g_div1
    logic signed [31:0] num, den;
    if (g < 3) begin : g_pt
      assign num = p[g];
      assign den = p[3];
    end else begin : g_org
      assign num = 32'(elem(cfg_q.row[g-3], 2'd3));
      assign den = 32'(elem(cfg_q.row[3], 2'd3));
    end
    rpg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .num_i (num),
      .den_i (den),
      .q_o   (q1[g])
    );
  end

  // Direction before normalization
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) d_q[r] <= 33'(q1[r]) - 33'(q1[r+3]);
    org_s_q <= {q1[5], q1[4], q1[3]};
  end

  rpg_norm u_norm (
    .clk_i  (clk_i),
    .d_i    (d_q),
    .dn_o   (dn),
    .sum_o  (sum),
    .zero_o (zero_n)
  );

  rpg_isqrt u_isqrt (
    .clk_i  (clk_i),
    .v_i    (sum),
    .root_o (root)
  );

  // Delay lines that keep side data aligned with the long units
  always_ff @(posedge clk_i) begin
    org_dl_q[0] <= org_s_q;
    for (int i = 1; i < OrgDly; i++) org_dl_q[i] <= org_dl_q[i-1];
    sq_dl_q[0] <= {zero_n, dn[2], dn[1], dn[0]};
    for (int i = 1; i < SqrtLat; i++) sq_dl_q[i] <= sq_dl_q[i-1];
    zd_dl_q[0] <= sq_dl_q[SqrtLat-1][96];
    for (int i = 1; i < DivLat; i++) zd_dl_q[i] <= zd_dl_q[i-1];
  end

  // Divide each component by the length
  for (genvar g = 0; g < 3; g++) begin : g_div2
    rpg_div #(.FRAC_BITS(FRAC_BITS)) u_div (
      .clk_i (clk_i),
      .num_i ($signed(sq_dl_q[SqrtLat-1][32*g +: 32])),
      .den_i ($signed({1'b0, root[30:0]})),
      .q_o   (q2[g])
    );
  end

  // Result register
  always_ff @(posedge clk_i) begin
    res_q.origin_x <= $signed(org_dl_q[OrgDly-1][31:0]);
    res_q.origin_y <= $signed(org_dl_q[OrgDly-1][63:32]);
    res_q.origin_z <= $signed(org_dl_q[OrgDly-1][95:64]);
    res_q.dir_x    <= zd_dl_q[DivLat-1] ? '0 : q2[0];
    res_q.dir_y    <= zd_dl_q[DivLat-1] ? '0 : q2[1];
    res_q.dir_z    <= zd_dl_q[DivLat-1] ? '0 : q2[2];
    zero_out_q     <= zd_dl_q[DivLat-1];
  end

  assign res_o       = res_q;
  assign res_valid_o = vld_q[PipeLat-1];

  // A scaled nonzero direction has its squared length in [2^58, 2^62)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[NormOut-1] && !zero_n |-> (sum >= 64'h0400_0000_0000_0000) &&
                                    (sum <  64'h4000_0000_0000_0000))
    else $error("normalized squared length out of range");

  // Length of a nonzero direction lies in [2^29, 2^31)
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[SqrtOut-1] && !sq_dl_q[SqrtLat-1][96] |->
      (root >= 32'h2000_0000) && (root < 32'h8000_0000))
    else $error("ray length out of range");

  // Unit direction components never exceed one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && !zero_out_q |->
      ($signed(res_q.dir_x) <= DirOne) && ($signed(res_q.dir_x) >= -DirOne) &&
      ($signed(res_q.dir_y) <= DirOne) && ($signed(res_q.dir_y) >= -DirOne) &&
      ($signed(res_q.dir_z) <= DirOne) && ($signed(res_q.dir_z) >= -DirOne))
    else $error("direction component exceeds unit length");

endmodule

FILE: rtl/rpg_front.sv
module rpg_front import rpg_pkg::*; #(
  parameter int PIXEL_COORD_BITS = 12,
  parameter int FRAC_BITS        = 16
) (
  input  logic               clk_i,
  input  pix_in_t            pix_i,
  input  cam_cfg_t           cfg_i,
  output logic signed [31:0] p_o [4]
);

  localparam int PxW   = (PIXEL_COORD_BITS < 12) ? PIXEL_COORD_BITS : 12;
  localparam int OddW  = PxW + 1;
  localparam int ProdW = OddW + 32;
  localparam int ScrW  = ProdW + 2;
  localparam logic signed [ScrW-1:0] TwoS = ScrW'(64'sd2 <<< FRAC_BITS);

  logic [ProdW-1:0]        prx_q, pry_q;
  logic signed [31:0]      sx_q, sy_q;
  logic signed [63:0]      tx_q, ty_q;
  logic signed [31:0]      vx_q, vy_q;
  logic signed [47:0]      pa_q [4];
  logic signed [47:0]      pb_q [4];
  logic signed [31:0]      p_q  [4];
  logic [OddW-1:0]         oddx, oddy;
  logic signed [ScrW-1:0]  dx, dy;

  // Pixel center times step: (2p+1)*step
  assign oddx = {pix_i.pixel_x[PxW-1:0], 1'b1};
  assign oddy = {pix_i.pixel_y[PxW-1:0], 1'b1};

  always_ff @(posedge clk_i) begin
    prx_q <= ProdW'(oddx) * ProdW'(cfg_i.step_x);
    pry_q <= ProdW'(oddy) * ProdW'(cfg_i.step_y);
  end

  // Shift to [-1,1) screen range and clamp
  assign dx = $signed({2'b00, prx_q}) - TwoS;
  assign dy = TwoS - $signed({2'b00, pry_q});

  always_ff @(posedge clk_i) begin
    sx_q <= sat32(64'(dx >>> 1));
    sy_q <= sat32(64'(dy >>> 1));
  end

  // Scale by the field-of-view tangents
  always_ff @(posedge clk_i) begin
    tx_q <= 64'(sx_q) * 64'($signed({1'b0, cfg_i.tan_half_fov_aspect}));
    ty_q <= 64'(sy_q) * 64'($signed({1'b0, cfg_i.tan_half_fov}));
  end

  always_ff @(posedge clk_i) begin
    vx_q <= sat32(tx_q >>> FRAC_BITS);
    vy_q <= sat32(ty_q >>> FRAC_BITS);
  end

  // Matrix products for the x and y columns
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      pa_q[r] <= 48'(elem(cfg_i.row[r], 2'd0)) * 48'(vx_q);
      pb_q[r] <= 48'(elem(cfg_i.row[r], 2'd1)) * 48'(vy_q);
    end
  end

  // Add the z = -1 and w = 1 columns, drop Q8.8 scaling, clamp
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 4; r++) begin
      p_q[r] <= sat32((64'(pa_q[r]) + 64'(pb_q[r])
                       - (64'(elem(cfg_i.row[r], 2'd2)) <<< FRAC_BITS)
                       + (64'(elem(cfg_i.row[r], 2'd3)) <<< FRAC_BITS)) >>> 8);
    end
  end

  assign p_o = p_q;

endmodule

FILE: rtl/rpg_div.sv
module rpg_div import rpg_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic signed [31:0] num_i,
  input  logic signed [31:0] den_i,
  output logic signed [31:0] q_o
);

  // One quotient bit per stage over the scaled numerator
  localparam int NW = 32 + FRAC_BITS;
  localparam logic [NW-1:0] Lim = NW'(64'h8000_0000);

  logic [NW-1:0] n_q   [NW+1];
  logic [31:0]   r_q   [NW+1];
  logic [NW-1:0] qt_q  [NW+1];
  logic [31:0]   d_q   [NW+1];
  logic          neg_q [NW+1];
  logic          zero_q[NW+1];
  logic          nneg_q[NW+1];
  logic signed [31:0] q_q;
  logic [31:0]   nmag, dmag;

  assign nmag = num_i[31] ? 32'(-num_i) : num_i;
  assign dmag = den_i[31] ? 32'(-den_i) : den_i;

  // Split into magnitudes and sign
  always_ff @(posedge clk_i) begin
    n_q[0]    <= NW'(nmag) << FRAC_BITS;
    r_q[0]    <= '0;
    qt_q[0]   <= '0;
    d_q[0]    <= dmag;
    neg_q[0]  <= num_i[31] ^ den_i[31];
    zero_q[0] <= (den_i == '0);
    nneg_q[0] <= num_i[31];
  end

  for (genvar s = 0; s < NW; s++) begin : g_it
    logic [32:0] sh;
    logic        ge;
    assign sh = {r_q[s], n_q[s][NW-1]};
    assign ge = (sh >= {1'b0, d_q[s]});
    // Restoring step: subtract where the divisor fits
    always_ff @(posedge clk_i) begin
      r_q[s+1]    <= ge ? 32'(sh - {1'b0, d_q[s]}) : sh[31:0];
      n_q[s+1]    <= n_q[s] << 1;
      qt_q[s+1]   <= {qt_q[s][NW-2:0], ge};
      d_q[s+1]    <= d_q[s];
      neg_q[s+1]  <= neg_q[s];
      zero_q[s+1] <= zero_q[s];
      nneg_q[s+1] <= nneg_q[s];
    end
  end

  // Apply sign, clamp, handle a zero divisor
  always_ff @(posedge clk_i) begin
    if (zero_q[NW]) begin
      q_q <= nneg_q[NW] ? S32Min : S32Max;
    end else if (neg_q[NW]) begin
      q_q <= (qt_q[NW] >= Lim) ? S32Min : -$signed(qt_q[NW][31:0]);
    end else begin
      q_q <= (qt_q[NW] >= Lim) ? S32Max : $signed(qt_q[NW][31:0]);
    end
  end

  assign q_o = q_q;

endmodule

FILE: rtl/rpg_isqrt.sv
module rpg_isqrt import rpg_pkg::*; (
  input  logic        clk_i,
  input  logic [63:0] v_i,
  output logic [31:0] root_o
);

  localparam int Steps = SqrtLat - 1;

  logic [63:0] v_q   [Steps+1];
  logic [63:0] res_q [Steps+1];

  always_ff @(posedge clk_i) begin
    v_q[0]   <= v_i;
    res_q[0] <= '0;
  end

  // One result bit per stage, trial bit walks down by powers of four
  for (genvar s = 0; s < Steps; s++) begin : g_it
    localparam logic [63:0] Bit = 64'd1 << (62 - 2*s);
    logic [63:0] t;
    logic        ge;
    assign t  = res_q[s] + Bit;
    assign ge = (v_q[s] >= t);
    always_ff @(posedge clk_i) begin
      v_q[s+1]   <= ge ? v_q[s] - t : v_q[s];
      res_q[s+1] <= ge ? (res_q[s] >> 1) + Bit : (res_q[s] >> 1);
    end
  end

  assign root_o = res_q[Steps][31:0];

endmodule

FILE: rtl/rpg_norm.sv
module rpg_norm import rpg_pkg::*; (
  input  logic               clk_i,
  input  logic signed [32:0] d_i   [3],
  output logic signed [31:0] dn_o  [3],
  output logic [63:0]        sum_o,
  output logic               zero_o
);

  logic signed [32:0] d1_q [3];
  logic signed [32:0] d2_q [3];
  logic signed [32:0] d3_q [3];
  logic signed [32:0] d4_q [3];
  logic [31:0]        mag_q [3];
  logic [31:0]        m_q;
  logic [3:0]         clen_q [4];
  logic [5:0]         blen_q;
  logic               z4_q, z5_q, z6_q, z7_q;
  logic signed [31:0] dn5_q [3];
  logic signed [31:0] dn6_q [3];
  logic signed [31:0] dn7_q [3];
  logic [63:0]        sq_q [3];
  logic [63:0]        sum_q;
  logic [31:0]        mx;
  logic [5:0]         blen;

  function automatic logic [3:0] bitlen8(input logic [7:0] b);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 8; i++) begin
      if (b[i]) n = 4'(i + 1);
    end
    return n;
  endfunction

  // Component magnitudes
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      mag_q[r] <= d_i[r][32] ? 32'(-d_i[r]) : d_i[r][31:0];
      d1_q[r]  <= d_i[r];
    end
  end

  // Largest magnitude
  always_comb begin
    mx = mag_q[0];
    if (mag_q[1] > mx) mx = mag_q[1];
    if (mag_q[2] > mx) mx = mag_q[2];
  end

  always_ff @(posedge clk_i) begin
    m_q  <= mx;
    d2_q <= d1_q;
  end

  // Bit length per byte
  always_ff @(posedge clk_i) begin
    for (int c = 0; c < 4; c++) clen_q[c] <= bitlen8(m_q[8*c +: 8]);
    d3_q <= d2_q;
  end

  // Bit length of the whole word from the top nonzero byte
  always_comb begin
    priority if (clen_q[3] != '0) blen = 6'd24 + 6'(clen_q[3]);
    else if (clen_q[2] != '0)     blen = 6'd16 + 6'(clen_q[2]);
    else if (clen_q[1] != '0)     blen = 6'd8 + 6'(clen_q[1]);
    else                          blen = 6'(clen_q[0]);
  end

  always_ff @(posedge clk_i) begin
    blen_q <= blen;
    z4_q   <= (blen == '0);
    d4_q   <= d3_q;
  end

  // Scale so the largest magnitude has 30 bits
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) begin
      if (blen_q > 6'd30) begin
        dn5_q[r] <= 32'(d4_q[r] >>> (blen_q - 6'd30));
      end else begin
        dn5_q[r] <= 32'(d4_q[r] <<< (6'd30 - blen_q));
      end
    end
    z5_q <= z4_q;
  end

  // Squares, then their sum
  always_ff @(posedge clk_i) begin
    for (int r = 0; r < 3; r++) sq_q[r] <= 64'(64'(dn5_q[r]) * 64'(dn5_q[r]));
    dn6_q <= dn5_q;
    z6_q  <= z5_q;
  end

  always_ff @(posedge clk_i) begin
    sum_q <= sq_q[0] + sq_q[1] + sq_q[2];
    dn7_q <= dn6_q;
    z7_q  <= z6_q;
  end

  assign dn_o   = dn7_q;
  assign sum_o  = sum_q;
  assign zero_o = z7_q;

endmodule
